// ===== hw/rtl/stack_mean_and_deviation_macros.svh =====
// Assertion macros for the stack mean / deviation block.
// Both expect clk and rst_n in the scope of use.
`ifndef STACK_MEAN_AND_DEVIATION_MACROS_SVH
`define STACK_MEAN_AND_DEVIATION_MACROS_SVH

// same-cycle implication
`define SMD_ASSERT_NOW(LBL, ANTE, CONS) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |-> (CONS)) \
    else $error("smd check failed");

// next-cycle implication
`define SMD_ASSERT_NEXT(LBL, ANTE, CONS) \
  LBL: assert property (@(posedge clk) disable iff (!rst_n) (ANTE) |=> (CONS)) \
    else $error("smd check failed");

`endif

// ===== hw/rtl/smd_pkg.sv =====
`default_nettype none

package smd_pkg;

  localparam int PIX_W  = 16;
  localparam int DEV_W  = 8;
  localparam int SUM_W  = 24;
  localparam int SQ_W   = 37;
  localparam int CNT_W  = 7;
  localparam int ABS_W  = SUM_W - 1;
  localparam int PROD_W = 2 * ABS_W;
  localparam int ROOT_W = PROD_W / 2;
  localparam int QUO_W  = ABS_W;

  localparam logic [DEV_W-1:0] DEV_CLAMP = DEV_W'(255);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROD,
    ST_START,
    ST_ROOT,
    ST_DEV
  } smd_state_t;

  typedef struct packed {
    logic acc;         // accumulate the input word
    logic prod;        // capture products, clear accumulators
    logic sqrt_start;
    logic div_start;
    logic div_dev;     // divider operand: 1 = root, 0 = |sum|
    logic mean_ld;
    logic out_load;
  } smd_cmd_t;

  typedef struct packed {
    logic sqrt_busy;
    logic div_busy;
  } smd_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/smd_sqrt.sv =====
`default_nettype none

// Integer square root, one root bit per cycle (two radicand bits).
module smd_sqrt (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start_i,
  input  wire logic [smd_pkg::PROD_W-1:0] rad_i,
  output logic                             busy_o,
  output logic      [smd_pkg::ROOT_W-1:0] root_o
);

  localparam int IT_W = $clog2(smd_pkg::ROOT_W + 1);

  logic [IT_W-1:0]                cnt_r;
  logic [smd_pkg::PROD_W-1:0]     rad_r;
  logic [smd_pkg::ROOT_W+1:0]     rem_r;
  logic [smd_pkg::ROOT_W-1:0]     root_r;

  logic [smd_pkg::ROOT_W+1:0]     rem_sh;
  logic [smd_pkg::ROOT_W+1:0]     trial;
  logic                           take;
  logic [smd_pkg::ROOT_W+1:0]     rem_nxt;
  logic [smd_pkg::ROOT_W-1:0]     root_nxt;

  assign busy_o = (cnt_r != '0);
  assign root_o = root_r;

  always_comb begin
    rem_sh   = {rem_r[smd_pkg::ROOT_W-1:0], rad_r[smd_pkg::PROD_W-1 -: 2]};
    trial    = {root_r, 2'b01};
    take     = (rem_sh >= trial);
    rem_nxt  = take ? (rem_sh - trial) : rem_sh;
    root_nxt = {root_r[smd_pkg::ROOT_W-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= IT_W'(smd_pkg::ROOT_W);
    end else if (busy_o) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      rad_r  <= rad_i;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_o) begin
      rad_r  <= rad_r << 2;
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/smd_div.sv =====
`default_nettype none

// Restoring unsigned divider, one quotient bit per cycle.
module smd_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start_i,
  input  wire logic [smd_pkg::QUO_W-1:0] dvd_i,
  input  wire logic [smd_pkg::CNT_W-1:0] dvs_i,
  output logic                            busy_o,
  output logic      [smd_pkg::QUO_W-1:0] quo_o
);

  localparam int IT_W = $clog2(smd_pkg::QUO_W + 1);

  logic [IT_W-1:0]              cnt_r;
  logic [smd_pkg::QUO_W-1:0]    quo_r;
  logic [smd_pkg::CNT_W-1:0]    rem_r;
  logic [smd_pkg::CNT_W-1:0]    dvs_r;

  logic [smd_pkg::CNT_W:0]      rem_sh;
  logic [smd_pkg::CNT_W:0]      rem_dif;
  logic                         fits;
  logic [smd_pkg::CNT_W-1:0]    rem_nxt;
  logic [smd_pkg::QUO_W-1:0]    quo_nxt;

  assign busy_o = (cnt_r != '0);
  assign quo_o  = quo_r;

  always_comb begin
    rem_sh  = {rem_r, quo_r[smd_pkg::QUO_W-1]};
    rem_dif = rem_sh - {1'b0, dvs_r};
    fits    = (rem_sh >= {1'b0, dvs_r});
    // remainder stays below the divisor, so CNT_W bits hold it
    rem_nxt = fits ? rem_dif[smd_pkg::CNT_W-1:0] : rem_sh[smd_pkg::CNT_W-1:0];
    quo_nxt = {quo_r[smd_pkg::QUO_W-2:0], fits};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start_i) begin
      cnt_r <= IT_W'(smd_pkg::QUO_W);
    end else if (busy_o) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      quo_r <= dvd_i;
      rem_r <= '0;
      dvs_r <= dvs_i;
    end else if (busy_o) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/smd_dp.sv =====
`default_nettype none

module smd_dp #(
  parameter int MAX_IMAGES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire smd_pkg::smd_cmd_t                 cmd_i,
  output smd_pkg::smd_stat_t                     stat_o,
  input  wire logic signed [smd_pkg::PIX_W-1:0] pixel_i,
  output logic signed      [smd_pkg::PIX_W-1:0] mean_o,
  output logic             [smd_pkg::DEV_W-1:0] dev_o
);

  // accumulators
  logic signed [smd_pkg::SUM_W-1:0]  sum_r;
  logic        [smd_pkg::SQ_W-1:0]   sqs_r;
  logic        [smd_pkg::CNT_W-1:0]  cnt_r;

  // per-stack working registers
  logic        [smd_pkg::ABS_W-1:0]  abs_r;
  logic                              neg_r;
  logic        [smd_pkg::CNT_W-1:0]  n_r;
  logic        [smd_pkg::PROD_W-1:0] scaled_r;
  logic        [smd_pkg::PROD_W-1:0] sq_r;
  logic        [smd_pkg::PIX_W-1:0]  mean_r;
  logic        [smd_pkg::PIX_W-1:0]  out_mean_r;
  logic        [smd_pkg::DEV_W-1:0]  out_dev_r;

  logic                                      full;
  logic signed [2*smd_pkg::PIX_W-1:0]        pix_sq;
  logic signed [smd_pkg::SUM_W-1:0]          sum_nxt;
  logic        [smd_pkg::SQ_W-1:0]           sqs_nxt;
  logic signed [2*smd_pkg::SUM_W-1:0]        sum_sq;
  logic [smd_pkg::CNT_W+smd_pkg::SQ_W-1:0]   scaled_full;
  logic        [smd_pkg::SUM_W-1:0]          abs_full;
  logic        [smd_pkg::PROD_W-1:0]         diff;
  logic        [smd_pkg::ROOT_W-1:0]         root;
  logic        [smd_pkg::QUO_W-1:0]          dvd;
  logic        [smd_pkg::QUO_W-1:0]          quo;
  logic        [smd_pkg::QUO_W-1:0]          mean_mag;
  logic                                      n_zero;
  logic                                      sqrt_busy;
  logic                                      div_busy;

  always_comb begin
    full    = (cnt_r >= smd_pkg::CNT_W'(MAX_IMAGES));
    pix_sq  = pixel_i * pixel_i;
    sum_nxt = sum_r + {{(smd_pkg::SUM_W - smd_pkg::PIX_W){pixel_i[smd_pkg::PIX_W-1]}}, pixel_i};
    sqs_nxt = sqs_r + {{(smd_pkg::SQ_W - 2*smd_pkg::PIX_W){1'b0}}, pix_sq};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sqs_r <= '0;
      cnt_r <= '0;
    end else if (cmd_i.prod) begin
      sum_r <= '0;
      sqs_r <= '0;
      cnt_r <= '0;
    end else if (cmd_i.acc && !full) begin
      sum_r <= sum_nxt;
      sqs_r <= sqs_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // sum squared straight from the signed sum; |sum| goes separately to the divider
  always_comb begin
    sum_sq      = sum_r * sum_r;
    scaled_full = cnt_r * sqs_r;
    abs_full    = sum_r[smd_pkg::SUM_W-1] ? (~sum_r + 1'b1) : sum_r;
  end

  always_ff @(posedge clk) begin
    if (cmd_i.prod) begin
      sq_r     <= sum_sq[smd_pkg::PROD_W-1:0];
      scaled_r <= {{(smd_pkg::PROD_W - smd_pkg::CNT_W - smd_pkg::SQ_W){1'b0}}, scaled_full};
      abs_r    <= abs_full[smd_pkg::ABS_W-1:0];
      neg_r    <= sum_r[smd_pkg::SUM_W-1];
      n_r      <= cnt_r;
    end
  end

  assign diff = (scaled_r >= sq_r) ? (scaled_r - sq_r) : '0;
  assign dvd  = cmd_i.div_dev ? root : abs_r;

  smd_sqrt u_sqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.sqrt_start),
    .rad_i   (diff),
    .busy_o  (sqrt_busy),
    .root_o  (root)
  );

  smd_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cmd_i.div_start),
    .dvd_i   (dvd),
    .dvs_i   (n_r),
    .busy_o  (div_busy),
    .quo_o   (quo)
  );

  assign stat_o.sqrt_busy = sqrt_busy;
  assign stat_o.div_busy  = div_busy;

  assign mean_mag = neg_r ? (~quo + 1'b1) : quo;
  assign n_zero   = (n_r == '0);

  always_ff @(posedge clk) begin
    if (cmd_i.mean_ld) begin
      mean_r <= mean_mag[smd_pkg::PIX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_i.out_load) begin
      if (n_zero) begin
        out_mean_r <= '0;
        out_dev_r  <= '0;
      end else begin
        out_mean_r <= mean_r;
        out_dev_r  <= (quo[smd_pkg::QUO_W-1:smd_pkg::DEV_W] != '0) ?
                      smd_pkg::DEV_CLAMP : quo[smd_pkg::DEV_W-1:0];
      end
    end
  end

  assign mean_o = $signed(out_mean_r);
  assign dev_o  = out_dev_r;

endmodule

`default_nettype wire

// ===== hw/rtl/smd_ctrl.sv =====
`default_nettype none

module smd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid_i,
  input  wire logic               in_last_i,
  output logic                    in_ready_o,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output smd_pkg::smd_cmd_t       cmd_o,
  input  wire smd_pkg::smd_stat_t stat_i
);

  smd_pkg::smd_state_t state_r;
  smd_pkg::smd_state_t state_nxt;
  logic                out_valid_r;
  logic                out_valid_nxt;
  logic                out_free;

  assign out_free = !out_valid_r || out_ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smd_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_r)
      smd_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.acc  = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_nxt = smd_pkg::ST_PROD;
        end
      end
      smd_pkg::ST_PROD: begin
        cmd_o.prod = 1'b1;
        state_nxt  = smd_pkg::ST_START;
      end
      smd_pkg::ST_START: begin
        // root and mean division run side by side
        cmd_o.sqrt_start = 1'b1;
        cmd_o.div_start  = 1'b1;
        state_nxt        = smd_pkg::ST_ROOT;
      end
      smd_pkg::ST_ROOT: begin
        if (!stat_i.sqrt_busy && !stat_i.div_busy) begin
          cmd_o.mean_ld   = 1'b1;
          cmd_o.div_start = 1'b1;
          cmd_o.div_dev   = 1'b1;
          state_nxt       = smd_pkg::ST_DEV;
        end
      end
      smd_pkg::ST_DEV: begin
        if (!stat_i.div_busy && out_free) begin
          cmd_o.out_load = 1'b1;
          state_nxt      = smd_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = smd_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  assign out_valid_o = out_valid_r;

endmodule

`default_nettype wire

// ===== hw/rtl/stack_mean_and_deviation.sv =====
// Accumulation takes one word per cycle while no stack is closing.
// A word with last set closes the stack, and input stalls while the result is computed: the
// 23-step root unit runs beside the 23-step shared divider for the mean, then the divider
// finds the deviation. A new stack is taken only after the result is loaded for output;
// an untaken result holds the close of the next stack, and with it the input.
// Reset (rst_n low at a clock edge) clears the accumulators, the controller and out_valid.
`default_nettype none

module stack_mean_and_deviation #(
  parameter int MAX_IMAGES = 64
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic signed [smd_pkg::PIX_W-1:0] in_pixel,
  input  wire logic                              in_last,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic signed      [smd_pkg::PIX_W-1:0] out_mean,
  output logic             [smd_pkg::DEV_W-1:0] out_deviation
);

  smd_pkg::smd_cmd_t  cmd;
  smd_pkg::smd_stat_t stat;

  smd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_valid),
    .in_last_i   (in_last),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .cmd_o       (cmd),
    .stat_i      (stat)
  );

  smd_dp #(
    .MAX_IMAGES (MAX_IMAGES)
  ) u_dp (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd_i   (cmd),
    .stat_o  (stat),
    .pixel_i (in_pixel),
    .mean_o  (out_mean),
    .dev_o   (out_deviation)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/smd_checker.sv =====
`default_nettype none

`include "stack_mean_and_deviation_macros.svh"

module smd_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              in_last,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic signed [smd_pkg::PIX_W-1:0] out_mean,
  input wire logic        [smd_pkg::DEV_W-1:0] out_deviation
);

  // stalled result holds
  `SMD_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_mean) && $stable(out_deviation))

  // closing a stack stops input
  `SMD_ASSERT_NEXT(a_busy_after_last, in_valid && in_ready && in_last, !in_ready)

  // input stalls only because a stack was closed
  `SMD_ASSERT_NOW(a_ready_fall, $fell(in_ready), $past(in_valid && in_last))

  // a new result only comes out of a closing computation
  `SMD_ASSERT_NOW(a_result_after_work, $rose(out_valid), !$past(in_ready))

endmodule

bind stack_mean_and_deviation smd_checker u_smd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .in_last       (in_last),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_mean      (out_mean),
  .out_deviation (out_deviation)
);

`default_nettype wire
